@@ design/clop_pkg.sv @@
package clop_pkg;

    localparam int MAX_POTS   = 64;
    localparam int VALUE_BITS = 16;
    localparam int TOT_W      = 22;

    localparam int IDX_W     = (MAX_POTS > 1) ? $clog2(MAX_POTS) : 1;
    localparam int CNT_W     = $clog2(MAX_POTS + 1);
    localparam int TBL_DEPTH = 1 << (2 * IDX_W);
    localparam int SUM_W     = ((VALUE_BITS > TOT_W) ? VALUE_BITS : TOT_W) + 1;
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    typedef struct packed {
        logic [VALUE_BITS-1:0] pot_value;
        logic                  last_pot;
    } t_in_item;

    typedef struct packed {
        logic [TOT_W-1:0] best_total;
        logic             too_many;
    } t_out_item;

    typedef enum logic [2:0] {
        STEP_WAIT  = 3'd0,
        STEP_RD    = 3'd1,
        STEP_FRONT = 3'd2,
        STEP_REAR  = 3'd3,
        STEP_WR    = 3'd4,
        STEP_DONE  = 3'd5,
        STEP_RET   = 3'd6
    } t_step;

    localparam int STEP_W = $bits(t_step);

    // Jump conditions; a step that does not jump moves on to the next one.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ROW_END,
        COND_MORE_CELLS,
        COND_OUT_FULL
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  rd_pair;
        logic  rd_third;
        logic  calc_rear;
        logic  write_cell;
        logic  emit;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic row_end;
        logic more_cells;
        logic out_full;
    } t_status;

    function automatic t_uword uprog(input t_step step);
        t_uword uw;
        uw = '{accept: 1'b0, rd_pair: 1'b0, rd_third: 1'b0, calc_rear: 1'b0,
               write_cell: 1'b0, emit: 1'b0, cond: COND_NEVER, target: STEP_WAIT};
        case (step)
            STEP_WAIT: begin
                uw.accept = 1'b1;
                uw.cond   = COND_NO_ROW_END;
                uw.target = STEP_WAIT;
            end
            STEP_RD: begin
                uw.rd_pair = 1'b1;
            end
            STEP_FRONT: begin
                uw.rd_third = 1'b1;
            end
            STEP_REAR: begin
                uw.calc_rear = 1'b1;
            end
            STEP_WR: begin
                uw.write_cell = 1'b1;
                uw.cond       = COND_MORE_CELLS;
                uw.target     = STEP_RD;
            end
            STEP_DONE: begin
                uw.emit   = 1'b1;
                uw.cond   = COND_OUT_FULL;
                uw.target = STEP_DONE;
            end
            STEP_RET: begin
                uw.cond   = COND_ALWAYS;
                uw.target = STEP_WAIT;
            end
            default: begin
                uw.cond   = COND_ALWAYS;
                uw.target = STEP_WAIT;
            end
        endcase
        return uw;
    endfunction

    function automatic logic [TOT_W-1:0] min_tot(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [TOT_W-1:0] max_tot(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Saturating at every cell gives the same answer as saturating the final
    // total, since add, min and max are all monotone.
    function automatic logic [TOT_W-1:0] sat_add(input logic [VALUE_BITS-1:0] v,
                                                 input logic [TOT_W-1:0] t);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(v) + SUM_W'(t);
        return (sum > SUM_W'(TOT_MAX)) ? TOT_MAX : sum[TOT_W-1:0];
    endfunction

endpackage

@@ design/clop_ram.sv @@
module clop_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                            o_rdata_a,
    output logic [WIDTH-1:0]                            o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ design/clop_seq.sv @@
module clop_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clop_pkg::t_status i_status,
    output clop_pkg::t_uword  o_uw,
    output clop_pkg::t_step   o_step
);
    import clop_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;
    logic   w_jump;

    always_comb begin
        w_uw = uprog(r_step);
    end

    always_comb begin
        case (w_uw.cond)
            COND_NEVER:      w_jump = 1'b0;
            COND_ALWAYS:     w_jump = 1'b1;
            COND_NO_ROW_END: w_jump = !i_status.row_end;
            COND_MORE_CELLS: w_jump = i_status.more_cells;
            COND_OUT_FULL:   w_jump = i_status.out_full;
            default:         w_jump = 1'b1;
        endcase
        n_step = w_jump ? w_uw.target : t_step'(r_step + STEP_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uw   = w_uw;
    assign o_step = r_step;

endmodule

@@ design/clop_dp.sv @@
module clop_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clop_pkg::t_uword    i_uw,
    output clop_pkg::t_status   o_status,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  clop_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output clop_pkg::t_out_item o_out_data
);
    import clop_pkg::*;

    logic [CNT_W-1:0]      r_count;
    logic                  r_over;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic [IDX_W-1:0]      r_i;
    logic [IDX_W-1:0]      r_j;
    logic [IDX_W-1:0]      r_d;
    logic [TOT_W-1:0]      r_front;
    logic [TOT_W-1:0]      r_rear;
    logic [TOT_W-1:0]      r_tm;
    logic [TOT_W-1:0]      r_best;
    logic [VALUE_BITS-1:0] r_potj;

    logic                  w_accept;
    logic                  w_row_end;
    logic                  w_room;
    logic                  w_j_last;
    logic                  w_d_last;
    logic                  w_emit;
    logic                  w_deep;
    logic [IDX_W-1:0]      w_i_p1;
    logic [IDX_W-1:0]      w_i_p2;
    logic [IDX_W-1:0]      w_j_m1;
    logic [IDX_W-1:0]      w_j_m2;
    logic [2*IDX_W-1:0]    w_tbl_raddr_a;
    logic [2*IDX_W-1:0]    w_tbl_raddr_b;
    logic [VALUE_BITS-1:0] w_pot_a;
    logic [VALUE_BITS-1:0] w_pot_b;
    logic [TOT_W-1:0]      w_tbl_a;
    logic [TOT_W-1:0]      w_tbl_b;
    logic [TOT_W-1:0]      w_near_front;
    logic [TOT_W-1:0]      w_near_rear;
    logic [TOT_W-1:0]      w_cell;

    assign o_in_stall = !i_uw.accept;
    assign w_accept   = i_in_valid && i_uw.accept;
    assign w_row_end  = w_accept && i_in_data.last_pot;
    assign w_room     = r_count < CNT_W'(MAX_POTS);
    assign w_emit     = i_uw.emit && !r_out_valid;

    assign w_j_last = (CNT_W'(r_j) + CNT_W'(1)) == r_count;
    assign w_d_last = (CNT_W'(r_d) + CNT_W'(1)) == r_count;

    // Every neighbor interval is empty on the first two diagonals.
    assign w_deep = r_d > IDX_W'(1);

    assign w_i_p1 = r_i + IDX_W'(1);
    assign w_i_p2 = r_i + IDX_W'(2);
    assign w_j_m1 = r_j - IDX_W'(1);
    assign w_j_m2 = r_j - IDX_W'(2);

    assign w_tbl_raddr_a = i_uw.rd_third ? {r_i, w_j_m2} : {w_i_p2, r_j};
    assign w_tbl_raddr_b = {w_i_p1, w_j_m1};

    assign o_status.row_end    = w_row_end;
    assign o_status.more_cells = !(w_j_last && w_d_last);
    assign o_status.out_full   = r_out_valid;

    clop_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_POTS)
    ) u_pot_ram (
        .i_clk     (i_clk),
        .i_we      (w_accept && w_room),
        .i_waddr   (r_count[IDX_W-1:0]),
        .i_wdata   (i_in_data.pot_value),
        .i_raddr_a (r_i),
        .i_raddr_b (r_j),
        .o_rdata_a (w_pot_a),
        .o_rdata_b (w_pot_b)
    );

    clop_ram #(
        .WIDTH (TOT_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk     (i_clk),
        .i_we      (i_uw.write_cell),
        .i_waddr   ({r_i, r_j}),
        .i_wdata   (w_cell),
        .i_raddr_a (w_tbl_raddr_a),
        .i_raddr_b (w_tbl_raddr_b),
        .o_rdata_a (w_tbl_a),
        .o_rdata_b (w_tbl_b)
    );

    assign w_near_front = w_deep ? min_tot(w_tbl_a, w_tbl_b) : '0;
    assign w_near_rear  = w_deep ? min_tot(r_tm, w_tbl_a) : '0;
    assign w_cell       = max_tot(r_front, r_rear);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_count <= '0;
                r_over  <= 1'b0;
            end else if (w_accept) begin
                if (w_room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_over <= 1'b1;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_row_end) begin
            r_i <= '0;
            r_j <= '0;
            r_d <= '0;
        end else if (i_uw.write_cell) begin
            if (w_j_last) begin
                r_i <= '0;
                r_j <= r_d + IDX_W'(1);
                r_d <= r_d + IDX_W'(1);
            end else begin
                r_i <= w_i_p1;
                r_j <= r_j + IDX_W'(1);
            end
        end
        // The step after the pair read sees both pots and the first two
        // neighbor cells on the RAM outputs.
        if (i_uw.rd_third) begin
            r_front <= sat_add(w_pot_a, w_near_front);
            r_potj  <= w_pot_b;
            r_tm    <= w_tbl_b;
        end
        if (i_uw.calc_rear) begin
            r_rear <= sat_add(r_potj, w_near_rear);
        end
        if (i_uw.write_cell) begin
            r_best <= w_cell;
        end
        if (w_emit) begin
            r_out.best_total <= r_best;
            r_out.too_many   <= r_over;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/coin_line_optimal_pick.sv @@
// Coins-in-a-line solver. Pots arrive one request each; the request marked
// last_pot closes the row, and one result then follows with the most coins the
// first player can be sure of. While waiting, a new pot is taken whenever one is
// offered. After the last pot, a microcoded sequencer fills the interval table
// one cell at a time, four steps per cell: read both pots and two neighbor
// cells, read the third neighbor cell while forming the front choice, form the
// rear choice, and write the cell. After the last cell, the done step places
// the result in the output register, waiting while that register is full.
// Pots past the capacity are dropped and the result reports too_many. The
// result waits in the output register; after it is placed, a return step leads
// back to the wait step, where loading of the next row starts.
module coin_line_optimal_pick (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  clop_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output clop_pkg::t_out_item o_out_data
);
    import clop_pkg::*;

    t_uword  w_uw;
    t_status w_status;
    t_step   w_step;

    clop_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_uw     (w_uw),
        .o_step   (w_step)
    );

    clop_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uw        (w_uw),
        .o_status    (w_status),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_take_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> w_step == STEP_WAIT)
        else $error("request taken outside the wait step");

    a_row_end_starts_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.row_end |=> w_step == STEP_RD)
        else $error("row end did not start the table fill");

    a_last_cell_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step == STEP_WR) && !w_status.more_cells |=> w_step == STEP_DONE)
        else $error("fill did not stop after the last cell");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_step == STEP_DONE))
        else $error("result appeared outside the done step");

endmodule

@@ verif/coin_line_optimal_pick_tb.sv @@
`timescale 1ns / 1ps

module coin_line_optimal_pick_tb;
    import clop_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 64;

    typedef enum int {
        VAL_RANDOM,
        VAL_SMALL,
        VAL_EXTREME,
        VAL_MIXED
    } val_mode_e;

    typedef struct {
        t_in_item item;
        bit       drain_first;
    } pot_req_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    pot_req_t  pot_queue[$];
    t_out_item due_totals[$];
    pot_req_t  next_req;
    logic      req_taken;

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_cnt;
    int mismatch_cnt;
    int results_checked;
    int rows_queued;
    int pots_queued;
    int long_rows;

    // Predictor state: the current row and the interval table.
    logic [VALUE_BITS-1:0] row_pots[MAX_POTS];
    int                    row_len;
    bit                    row_overflow;
    longint unsigned       pick_tbl[MAX_POTS][MAX_POTS];

    coin_line_optimal_pick u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned interval_val(input int i, input int j);
        if (i < 0 || j < 0 || i > j || j >= MAX_POTS) begin
            return 0;
        end
        return pick_tbl[i][j];
    endfunction

    function automatic logic [TOT_W-1:0] solve_pick_total(input int n);
        longint unsigned mid, front, rear, opp_front, opp_rear;
        int d, i, j;
        if (n <= 0) begin
            return '0;
        end
        for (d = 0; d < n; d++) begin
            for (i = 0; i + d < n; i++) begin
                j = i + d;
                mid = interval_val(i + 1, j - 1);
                opp_front = interval_val(i + 2, j);
                opp_rear = interval_val(i, j - 2);
                front = row_pots[i] + ((opp_front < mid) ? opp_front : mid);
                rear = row_pots[j] + ((mid < opp_rear) ? mid : opp_rear);
                pick_tbl[i][j] = (front > rear) ? front : rear;
            end
        end
        if (pick_tbl[0][n-1] > longint'(TOT_MAX)) begin
            return TOT_MAX;
        end
        return pick_tbl[0][n-1][TOT_W-1:0];
    endfunction

    task automatic take_pot(input t_in_item it);
        t_out_item res;
        if (row_len < MAX_POTS) begin
            row_pots[row_len] = it.pot_value;
            row_len++;
        end else begin
            row_overflow = 1'b1;
        end
        if (it.last_pot) begin
            res.best_total = solve_pick_total(row_len);
            res.too_many = row_overflow;
            due_totals.push_back(res);
            row_len = 0;
            row_overflow = 1'b0;
        end
    endtask

    task automatic check_total(input t_out_item got);
        t_out_item want;
        if (due_totals.size() == 0) begin
            if (mismatch_cnt < 10) begin
                $display("Unexpected result: best_total=%0d too_many=%0b",
                         got.best_total, got.too_many);
            end
            mismatch_cnt++;
        end else begin
            want = due_totals.pop_front();
            results_checked++;
            if (got.best_total !== want.best_total || got.too_many !== want.too_many) begin
                if (mismatch_cnt < 10) begin
                    $display("Mismatch on result %0d: best_total exp %0d got %0d, %s",
                             results_checked, want.best_total, got.best_total,
                             $sformatf("too_many exp %0b got %0b",
                                       want.too_many, got.too_many));
                end
                mismatch_cnt++;
            end
        end
    endtask

    // Driver: a request stays on the bus until it is taken.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || req_taken) begin
            if (pot_queue.size() != 0
                && !(pot_queue[0].drain_first && due_totals.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
                next_req = pot_queue.pop_front();
                in_data <= next_req.item;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: results are checked before the same edge's request is predicted.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall) begin
                check_total(out_data);
            end
            if (in_valid && !in_stall) begin
                take_pot(in_data);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [VALUE_BITS-1:0] pick_value(input val_mode_e mode);
        val_mode_e m;
        m = mode;
        if (m == VAL_MIXED) begin
            m = val_mode_e'($urandom_range(2));
        end
        case (m)
            VAL_SMALL:   return VALUE_BITS'($urandom_range(15));
            VAL_EXTREME: return $urandom_range(1) ? {VALUE_BITS{1'b1}} : '0;
            default:     return VALUE_BITS'($urandom_range(65535));
        endcase
    endfunction

    task automatic push_pot(input logic [VALUE_BITS-1:0] value, input bit last,
                            input bit drain);
        pot_req_t r;
        r.item.pot_value = value;
        r.item.last_pot = last;
        r.drain_first = drain;
        pot_queue.push_back(r);
        pots_queued++;
        if (last) begin
            rows_queued++;
        end
    endtask

    task automatic add_row(input int len, input val_mode_e mode, input bit drain);
        int k;
        for (k = 0; k < len; k++) begin
            push_pot(pick_value(mode), k == len - 1, drain && k == 0);
        end
        if (len >= MAX_POTS) begin
            long_rows++;
        end
    endtask

    task automatic fill_phase(input int budget);
        int target, len, r;
        val_mode_e mode;
        target = pots_queued + budget;
        while (pots_queued < target) begin
            r = $urandom_range(99);
            if (r < 10) begin
                len = 1;
            end else if (r < 20) begin
                len = 2;
            end else if (r < 85) begin
                len = $urandom_range(12, 3);
            end else if (r < 97) begin
                len = $urandom_range(24, 13);
            end else begin
                len = $urandom_range(40, 25);
            end
            r = $urandom_range(99);
            if (r < 40) begin
                mode = VAL_RANDOM;
            end else if (r < 55) begin
                mode = VAL_SMALL;
            end else if (r < 70) begin
                mode = VAL_EXTREME;
            end else begin
                mode = VAL_MIXED;
            end
            add_row(len, mode, $urandom_range(99) < 8);
        end
    endtask

    task automatic wait_drained();
        while (pot_queue.size() != 0 || in_valid || due_totals.size() != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        req_taken = 1'b0;
        row_len = 0;
        row_overflow = 1'b0;
        cycle_cnt = 0;
        mismatch_cnt = 0;
        results_checked = 0;
        rows_queued = 0;
        pots_queued = 0;
        long_rows = 0;
        send_idle_pct = 22;
        recv_stall_pct = 88;

        // Directed rows of one to five pots: extremes and alternating bit patterns.
        push_pot('0, 1'b1, 1'b0);
        push_pot(16'hFFFF, 1'b1, 1'b0);
        push_pot(16'hFFFF, 1'b0, 1'b0);
        push_pot('0, 1'b1, 1'b0);
        push_pot('0, 1'b0, 1'b1);
        push_pot(16'hFFFF, 1'b1, 1'b0);
        push_pot(16'd1, 1'b0, 1'b0);
        push_pot(16'hFFFF, 1'b0, 1'b0);
        push_pot(16'd2, 1'b1, 1'b0);
        push_pot(16'hAAAA, 1'b0, 1'b0);
        push_pot(16'h5555, 1'b0, 1'b0);
        push_pot(16'h5555, 1'b0, 1'b0);
        push_pot(16'hAAAA, 1'b1, 1'b0);
        repeat (4) push_pot(16'hFFFF, 1'b0, 1'b0);
        push_pot(16'hFFFF, 1'b1, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A full row, then one whose last pot no longer fits.
        add_row(MAX_POTS, VAL_RANDOM, 1'b1);
        add_row(MAX_POTS + 1, VAL_MIXED, 1'b0);
        fill_phase(230);
        wait_drained();

        send_idle_pct = 88;
        recv_stall_pct = 22;
        add_row($urandom_range(MAX_POTS + 16, MAX_POTS + 2), VAL_RANDOM, 1'b1);
        fill_phase(300);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        fill_phase(380);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_totals.size() != 0) begin
            $display("%0d expected results never arrived", due_totals.size());
            mismatch_cnt += due_totals.size();
        end
        $display("Checked %0d row results from %0d pots, %0d rows at or past capacity,",
                 results_checked, pots_queued, long_rows);
        $display("under slow-sender, slow-receiver and full-rate traffic; %0d mismatches.",
                 mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ coin_line_optimal_pick.f @@
design/clop_pkg.sv
design/clop_ram.sv
design/clop_seq.sv
design/clop_dp.sv
design/coin_line_optimal_pick.sv
verif/coin_line_optimal_pick_tb.sv
